[hdl/psa_pkg.sv]
// shared types, codes and constants of the policy select arbiter
package psa_pkg;

    localparam int PSA_SLOTS = 16;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    localparam logic [1:0] MODE_RR   = 2'd0;
    localparam logic [1:0] MODE_PRIO = 2'd1;
    localparam logic [1:0] MODE_PRR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN1,
        ST_MOD,
        ST_SCAN2,
        ST_RESULT
    } psa_state_t;

    typedef struct packed {
        logic clear;
        logic write;
        logic scan_start;
        logic scan1;
        logic mod_step;
        logic scan2;
        logic load;
    } psa_cmd_t;

    typedef struct packed {
        logic is_write;
        logic scan_done;
        logic rotate_ok;
        logic mod_done;
        logic out_free;
    } psa_status_t;

endpackage

[hdl/psa_ram.sv]
// generic single write port ram with registered read
module psa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/psa_ctrl.sv]
// sequencing state machine of the policy select arbiter
module psa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  psa_pkg::psa_status_t status,
    output psa_pkg::psa_cmd_t    cmd
);
    import psa_pkg::*;

    psa_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_START;
            end
            ST_START: begin
                state_next = status.is_write ? ST_RESULT : ST_SCAN1;
            end
            ST_SCAN1: begin
                if (status.scan_done) state_next = status.rotate_ok ? ST_MOD : ST_RESULT;
            end
            ST_MOD: begin
                if (status.mod_done) state_next = ST_SCAN2;
            end
            ST_SCAN2: begin
                if (status.scan_done) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_START: begin
                cmd.clear      = 1'b1;
                cmd.write      = status.is_write;
                cmd.scan_start = ~status.is_write;
            end
            ST_SCAN1: begin
                cmd.scan1 = 1'b1;
            end
            ST_MOD: begin
                cmd.mod_step   = ~status.mod_done;
                cmd.scan_start = status.mod_done;
            end
            ST_SCAN2: begin
                cmd.scan2 = 1'b1;
            end
            ST_RESULT: begin
                cmd.load = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hdl/psa_datapath.sv]
// slot table, scan accumulators, modulo reduction and result register
module psa_datapath #(
    parameter int SLOTS = psa_pkg::PSA_SLOTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_wdata,
    input  logic                            s_accept,
    input  logic [psa_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [psa_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tuser,
    input  psa_pkg::psa_cmd_t               cmd,
    output psa_pkg::psa_status_t            status
);
    import psa_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ENT_W = 9;

    // captured input item
    logic              func_reg;
    logic [3:0]        slot_reg;
    logic              run_in_reg;
    logic [7:0]        pri_in_reg;

    logic [1:0]        mode_reg;
    logic [IDX_W-1:0]  rot_reg;
    logic [SLOTS-1:0]  valid_reg;

    // scan pipeline
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic              pipe_vld_reg;
    logic [IDX_W-1:0]  pipe_idx_reg;
    logic              valid_q_reg;
    logic [ENT_W-1:0]  ram_q;

    // accumulators
    logic              found_reg;
    logic signed [7:0] best_reg;
    logic [IDX_W-1:0]  first_reg;
    logic [CNT_W-1:0]  run_n_reg;
    logic [CNT_W-1:0]  tie_n_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  k_reg;
    logic              picked_reg;
    logic [IDX_W-1:0]  pick_reg;

    logic              m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;

    logic [IDX_W+3:0]  slot_wide;
    logic              wr_ok;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic              scan_run;
    logic              issue;
    logic              e_run;
    logic signed [7:0] e_pri;
    logic              cand;
    logic [CNT_W-1:0]  n_sel;
    logic              rotating;
    logic [CNT_W-1:0]  rem_inc;
    logic [CNT_W+IDX_W-1:0] rot_wide;
    logic [IDX_W+3:0]  grant_wide;
    logic [CNT_W+4:0]  cnt_wide;
    logic              res_valid;
    logic [3:0]        res_slot;
    logic [4:0]        res_count;

    assign slot_wide = {{IDX_W{1'b0}}, slot_reg};
    assign wr_addr   = slot_wide[IDX_W-1:0];
    assign wr_ok     = (int'(slot_reg) < SLOTS);
    assign rd_addr   = scan_cnt_reg[IDX_W-1:0];
    assign scan_run  = cmd.scan1 | cmd.scan2;
    assign issue     = scan_run && (int'(scan_cnt_reg) < SLOTS);

    psa_ram #(
        .WIDTH(ENT_W),
        .DEPTH(SLOTS)
    ) u_table (
        .clk  (aclk),
        .we   (cmd.write & wr_ok),
        .waddr(wr_addr),
        .wdata({run_in_reg, pri_in_reg}),
        .raddr(rd_addr),
        .rdata(ram_q)
    );

    // never written entries read as not runnable, priority zero
    assign e_run = valid_q_reg & ram_q[8];
    assign e_pri = valid_q_reg ? signed'(ram_q[7:0]) : 8'sd0;

    assign rotating = (mode_reg == MODE_RR) || (mode_reg == MODE_PRR);
    assign n_sel    = (mode_reg == MODE_RR) ? run_n_reg : tie_n_reg;
    assign cand     = e_run && ((mode_reg == MODE_RR) || (e_pri == best_reg));
    assign rem_inc  = rem_reg + 1'b1;
    assign rot_wide = {{CNT_W{1'b0}}, rot_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_RR;
            rot_reg      <= '0;
            valid_reg    <= '0;
            scan_cnt_reg <= '0;
            pipe_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) mode_reg <= cfg_wdata;
            if (cmd.write && wr_ok) valid_reg[wr_addr] <= 1'b1;
            if (cmd.scan_start) begin
                scan_cnt_reg <= '0;
                pipe_vld_reg <= 1'b0;
            end else if (scan_run) begin
                pipe_vld_reg <= issue;
                if (issue) scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (cmd.load && func_reg == FUNC_SELECT && found_reg && rotating) begin
                rot_reg <= (rem_inc == n_sel) ? '0 : rem_inc[IDX_W-1:0];
            end
            if (cmd.load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        res_valid  = 1'b0;
        res_slot   = 4'd0;
        res_count  = 5'd0;
        grant_wide = '0;
        cnt_wide   = {5'd0, n_sel};
        if (func_reg == FUNC_SELECT && found_reg) begin
            case (mode_reg)
                MODE_RR, MODE_PRR: begin
                    grant_wide = {4'd0, pick_reg};
                    res_valid  = 1'b1;
                    res_slot   = grant_wide[3:0];
                    res_count  = cnt_wide[4:0];
                end
                MODE_PRIO: begin
                    grant_wide = {4'd0, first_reg};
                    res_valid  = 1'b1;
                    res_slot   = grant_wide[3:0];
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg   <= s_tuser;
            slot_reg   <= s_tdata[3:0];
            run_in_reg <= s_tdata[4];
            pri_in_reg <= s_tdata[12:5];
        end
        pipe_idx_reg <= rd_addr;
        valid_q_reg  <= valid_reg[rd_addr];
        if (cmd.clear) begin
            found_reg  <= 1'b0;
            best_reg   <= 8'sd0;
            first_reg  <= '0;
            run_n_reg  <= '0;
            tie_n_reg  <= '0;
            rem_reg    <= rot_wide[CNT_W-1:0];
            k_reg      <= '0;
            picked_reg <= 1'b0;
            pick_reg   <= '0;
        end else if (cmd.scan1 && pipe_vld_reg) begin
            if (e_run) run_n_reg <= run_n_reg + 1'b1;
            if (e_run && (!found_reg || e_pri < best_reg)) begin
                found_reg <= 1'b1;
                best_reg  <= e_pri;
                first_reg <= pipe_idx_reg;
                tie_n_reg <= {{(CNT_W-1){1'b0}}, 1'b1};
            end else if (e_run && e_pri == best_reg) begin
                tie_n_reg <= tie_n_reg + 1'b1;
            end
        end else if (cmd.mod_step) begin
            rem_reg <= rem_reg - n_sel;
        end else if (cmd.scan2 && pipe_vld_reg && cand) begin
            // pick the candidate whose rank matches the reduced index
            if (!picked_reg && k_reg == rem_reg) begin
                picked_reg <= 1'b1;
                pick_reg   <= pipe_idx_reg;
            end
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.load) begin
            m_tuser_reg <= res_valid;
            m_tdata_reg <= {7'd0, res_count, res_slot};
        end
    end

    assign status.is_write  = (func_reg == FUNC_WRITE);
    assign status.scan_done = (int'(scan_cnt_reg) == SLOTS) && !pipe_vld_reg;
    assign status.rotate_ok = found_reg && rotating;
    assign status.mod_done  = (rem_reg < n_sel);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[hdl/policy_select_arbiter.sv]
// top level of the policy select arbiter
// A table of SLOTS entries, each a runnable flag and a signed priority (lower is more
// urgent), is written and queried by items on the slave stream; every item returns
// exactly one result item. A select item scans the table once through its one-read-port
// ram; when a runnable entry is found, the rotating policies then reduce the rotation
// index by repeated subtraction and scan a second time. The result is loaded only once
// the previous result has left the output register. One item is in work at a time;
// the next is accepted while the previous result still waits on the master side.
// The policy register may only be written while no item is in work.
module policy_select_arbiter #(
    parameter int SLOTS = psa_pkg::PSA_SLOTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_wdata,   // policy_mode
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [psa_pkg::IN_DATA_W-1:0]  s_tdata,     // slot, runnable, priority_value
    input  logic                           s_tuser,     // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [psa_pkg::OUT_DATA_W-1:0] m_tdata,     // grant_slot, candidate_count
    output logic                           m_tuser      // grant_valid
);
    import psa_pkg::*;

    psa_cmd_t    cmd;
    psa_status_t status;
    logic        s_accept;

    assign s_accept = s_tvalid & s_tready;

    psa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    psa_datapath #(
        .SLOTS(SLOTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_accept (s_accept),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

[tb/policy_select_arbiter_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench of the policy select arbiter: directed and random items
module policy_select_arbiter_tb;
    import psa_pkg::*;

    // mode three has no name in the package; the block grants nothing there
    localparam logic [1:0] MODE_NONE  = 2'd3;
    localparam int         QUIET_LIMIT = 3000;
    localparam int         SHOW_LIMIT  = 10;

    typedef struct packed {
        logic       valid;
        logic [3:0] slot;
        logic [4:0] count;
    } grant_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // slot, runnable, priority_value
    logic                  s_tuser   = 1'b0; // func
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // grant_slot, candidate_count
    logic                  m_tuser;          // grant_valid

    // shadow copy of the slot table, rotation and policy
    logic        slot_run  [PSA_SLOTS];
    logic [7:0]  slot_prio [PSA_SLOTS];
    int unsigned rot_idx;
    logic [1:0]  policy;

    grant_t grant_q[$];
    int     mismatches    = 0;
    int     quiet_cycles  = 0;
    int     send_idle_pct = 12;
    int     recv_idle_pct = 55;

    policy_select_arbiter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // applies one item to the shadow table and returns the grant it should produce
    function automatic grant_t predict_grant(input logic func, input logic [3:0] slot,
                                             input logic run, input logic [7:0] prio);
        grant_t             g;
        int                 cand [PSA_SLOTS];
        int                 n;
        int                 idx;
        logic               found;
        logic signed [7:0]  best;
        g     = '0;
        n     = 0;
        found = 1'b0;
        best  = '0;
        if (func == FUNC_WRITE) begin
            slot_run[slot]  = run;
            slot_prio[slot] = prio;
        end else if (policy == MODE_RR) begin
            for (int i = 0; i < PSA_SLOTS; i++) begin
                if (slot_run[i]) begin
                    cand[n] = i;
                    n++;
                end
            end
            g.valid = (n > 0);
        end else if (policy == MODE_PRIO || policy == MODE_PRR) begin
            for (int i = 0; i < PSA_SLOTS; i++) begin
                if (slot_run[i] && (!found || $signed(slot_prio[i]) < best)) begin
                    best   = slot_prio[i];
                    g.slot = i[3:0];
                    found  = 1'b1;
                end
            end
            g.valid = found;
            // ties at the best priority rotate only in the mixed mode
            if (found && policy == MODE_PRR) begin
                for (int i = 0; i < PSA_SLOTS; i++) begin
                    if (slot_run[i] && slot_prio[i] == best) begin
                        cand[n] = i;
                        n++;
                    end
                end
            end
        end
        if (n > 0) begin
            idx     = rot_idx % n;
            g.slot  = cand[idx][3:0];
            g.count = n[4:0];
            rot_idx = (idx + 1) % n;
        end
        return g;
    endfunction

    task automatic send_item(input logic func, input logic [3:0] slot, input logic run,
                             input logic [7:0] prio);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = {3'b000, prio, run, slot};
        do @(posedge aclk); while (!s_tready);
        grant_q = {grant_q, predict_grant(func, slot, run, prio)};
    endtask

    task automatic write_slot(input logic [3:0] slot, input logic run, input logic [7:0] prio);
        send_item(FUNC_WRITE, slot, run, prio);
    endtask

    // slot fields are ignored on a select, so they carry noise
    task automatic select_grant();
        send_item(FUNC_SELECT, 4'($urandom_range(15)), 1'($urandom_range(1)),
                  8'($urandom_range(255)));
    endtask

    task automatic wait_for_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (grant_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_policy(input logic [1:0] mode);
        wait_for_idle();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = mode;
        @(negedge aclk);
        cfg_we    = 1'b0;
        policy    = mode;
    endtask

    task automatic test_empty_table();
        select_grant();
    endtask

    task automatic test_round_robin();
        write_slot(4'd0, 1'b1, 8'h00);
        write_slot(4'd15, 1'b1, 8'h00);
        write_slot(4'd7, 1'b1, 8'h7F);
        repeat (4) select_grant();
        // shrinking the set changes the count that the index is reduced by
        write_slot(4'd15, 1'b0, 8'h80);
        repeat (2) select_grant();
    endtask

    task automatic test_strict_priority();
        set_policy(MODE_PRIO);
        write_slot(4'd9, 1'b1, 8'h80);
        write_slot(4'd12, 1'b1, 8'h80);
        write_slot(4'd3, 1'b1, 8'h7F);
        repeat (2) select_grant();
    endtask

    task automatic test_priority_rotation();
        set_policy(MODE_PRR);
        repeat (3) select_grant();
        write_slot(4'd9, 1'b0, 8'h00);
        select_grant();
    endtask

    task automatic test_mode_three();
        set_policy(MODE_NONE);
        select_grant();
        write_slot(4'd5, 1'b1, 8'hFF);
        select_grant();
    endtask

    task automatic random_item();
        logic       func;
        logic [3:0] slot;
        logic       run;
        logic [7:0] prio;
        int         pick;
        if ($urandom_range(99) < 2)
            wait_for_idle();
        func = ($urandom_range(99) < 50) ? FUNC_SELECT : FUNC_WRITE;
        slot = 4'($urandom_range(15));
        run  = ($urandom_range(99) < 70);
        pick = $urandom_range(99);
        // a narrow band of priorities makes ties common
        if (pick < 60) begin
            prio = 8'($urandom_range(4));
            prio = prio - 8'd2;
        end else if (pick < 80) begin
            prio = $urandom_range(1) ? 8'h80 : 8'h7F;
        end else begin
            prio = 8'($urandom_range(255));
        end
        send_item(func, slot, run, prio);
    endtask

    task automatic test_random_traffic();
        logic [1:0] modes [5];
        modes = '{MODE_RR, MODE_PRIO, MODE_PRR, MODE_RR, MODE_PRR};
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 55;
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int b = 0; b < 5; b++) begin
                set_policy(modes[b]);
                repeat (80) random_item();
            end
            set_policy(MODE_NONE);
            repeat (10) random_item();
        end
    endtask

    initial begin
        for (int i = 0; i < PSA_SLOTS; i++) begin
            slot_run[i]  = 1'b0;
            slot_prio[i] = '0;
        end
        rot_idx = 0;
        policy  = MODE_RR;
        @(posedge aresetn);
        test_empty_table();
        test_round_robin();
        test_strict_priority();
        test_priority_rotation();
        test_mode_three();
        test_random_traffic();
        wait_for_idle();
        repeat (56) @(posedge aclk);
        if (mismatches == 0 && grant_q.size() == 0) begin
            $display("policy_select_arbiter verification clean");
        end else begin
            $display("policy_select_arbiter verification failed");
        end
        $finish;
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        grant_t got;
        grant_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("policy_select_arbiter verification failed");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[3:0], m_tdata[8:4]};
                if (grant_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("unexpected grant item valid=%0d slot=%0d count=%0d",
                                 got.valid, got.slot, got.count);
                end else begin
                    want = grant_q.pop_front();
                    if (got.valid !== want.valid || got.slot !== want.slot
                            || got.count !== want.count) begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT)
                            $display("grant mismatch: expected valid=%0d slot=%0d count=%0d, %s",
                                     want.valid, want.slot, want.count,
                                     $sformatf("got valid=%0d slot=%0d count=%0d",
                                               got.valid, got.slot, got.count));
                    end
                end
            end
        end
    end

endmodule
